@@ hw/rtl/counting_semaphore_fifo_waiters_assert.svh @@
// Assertion macros for the semaphore block
`ifndef COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH
`define COUNTING_SEMAPHORE_FIFO_WAITERS_ASSERT_SVH
`ifndef SYNTHESIS
`define CSFW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define CSFW_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define CSFW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CSFW_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ hw/rtl/csfw_pkg.sv @@
// Constants and codes shared by the semaphore block
`timescale 1ns / 1ps
package csfw_pkg;
	localparam int QUEUE_DEPTH = 16;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int COUNT_W     = 16;
	localparam int ID_W        = 8;
	localparam int OP_W        = 2;
	localparam int EV_W        = 3;

	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [OP_W-1:0] OP_WAIT   = 2'd0;
	localparam logic [OP_W-1:0] OP_SIGNAL = 2'd1;
	localparam logic [OP_W-1:0] OP_CLOSE  = 2'd2;

	localparam logic [EV_W-1:0] EV_GRANTED      = 3'd0;
	localparam logic [EV_W-1:0] EV_BLOCKED      = 3'd1;
	localparam logic [EV_W-1:0] EV_RAISED       = 3'd2;
	localparam logic [EV_W-1:0] EV_READY        = 3'd3;
	localparam logic [EV_W-1:0] EV_DEAD         = 3'd4;
	localparam logic [EV_W-1:0] EV_FULL         = 3'd5;
	localparam logic [EV_W-1:0] EV_CLOSED_EMPTY = 3'd6;
endpackage

@@ hw/rtl/csfw_ifs.sv @@
// Request and result channel interfaces
`timescale 1ns / 1ps
interface csfw_req_if;
	import csfw_pkg::*;
	logic            valid;
	logic            ready;
	logic [OP_W-1:0] opcode;
	logic [ID_W-1:0] requester_id;
	modport source (output valid, opcode, requester_id, input ready);
	modport sink (input valid, opcode, requester_id, output ready);
endinterface

interface csfw_rsp_if;
	import csfw_pkg::*;
	logic               valid;
	logic               ready;
	logic [EV_W-1:0]    event_res;
	logic [ID_W-1:0]    thread_id;
	logic [COUNT_W-1:0] count_now;
	logic               last;
	modport source (output valid, event_res, thread_id, count_now, last, input ready);
	modport sink (input valid, event_res, thread_id, count_now, last, output ready);
endinterface

@@ hw/rtl/csfw_ram.sv @@
// Generic single write, single read RAM with registered read data
`timescale 1ns / 1ps
module csfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

@@ hw/rtl/counting_semaphore_fifo_waiters.sv @@
// Counting semaphore with a FIFO of waiting thread ids
//
//  channel  dir  handshake     payload
//  req      in   valid/ready   opcode, requester_id
//  rsp      out  valid/ready   event_res, thread_id, count_now, last
//  cfg      in   cfg_we        cfg_wdata (initial_count)
//
// Wait, raised signal and close on an empty queue are answered directly from ST_IDLE. Signal that
// releases a waiter passes through ST_POP, which takes the registered read of the waiter RAM.
// Close with n waiters sends n dead words, one per cycle while rsp is ready.
// Reset clears pointers, occupancy and count; the waiter RAM needs no clearing.
// A stalled rsp holds the result; req is taken again once the slot is free.
`timescale 1ns / 1ps
`include "counting_semaphore_fifo_waiters_assert.svh"
module counting_semaphore_fifo_waiters (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [csfw_pkg::COUNT_W-1:0] cfg_wdata,
	csfw_req_if.sink                  req,
	csfw_rsp_if.source                rsp
);
	import csfw_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_POP   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;

	logic [1:0]         st_q, st_d;
	logic [COUNT_W-1:0] init_q;
	logic [COUNT_W-1:0] count_q, count_d;
	logic [PTR_W-1:0]   head_q, head_d, tail_q, tail_d;
	logic [OCC_W-1:0]   occ_q, occ_d;
	logic               ov_q, ov_d;
	logic [EV_W-1:0]    ev_q, ev_d;
	logic [ID_W-1:0]    tid_q, tid_d;
	logic [COUNT_W-1:0] cnt_out_q;
	logic               last_q, last_d;
	logic               load;

	logic               acc, out_free, is_full;
	logic               ram_we, ram_re;
	logic [ID_W-1:0]    ram_rdata;

	csfw_ram #(.WIDTH(ID_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (req.requester_id),
		.re    (ram_re),
		.raddr (head_q),
		.rdata (ram_rdata)
	);

	assign out_free  = !ov_q || rsp.ready;
	assign req.ready = (st_q == ST_IDLE) && out_free;
	assign acc       = req.valid && req.ready;
	assign is_full   = (occ_q == OCC_W'(QUEUE_DEPTH));

	always_comb begin
		st_d    = st_q;
		count_d = count_q;
		head_d  = head_q;
		tail_d  = tail_q;
		occ_d   = occ_q;
		ov_d    = ov_q && !rsp.ready;
		ram_we  = 1'b0;
		ram_re  = 1'b0;
		load    = 1'b0;
		ev_d    = EV_GRANTED;
		tid_d   = req.requester_id;
		last_d  = 1'b1;
		case (st_q)
			ST_IDLE: begin
				if (acc) begin
					case (req.opcode)
						OP_WAIT: begin
							load = 1'b1;
							if (count_q != '0) begin
								count_d = count_q - 1'b1;
								ev_d    = EV_GRANTED;
							end else if (is_full) begin
								ev_d = EV_FULL;
							end else begin
								ram_we = 1'b1;
								tail_d = tail_q + 1'b1;
								occ_d  = occ_q + 1'b1;
								ev_d   = EV_BLOCKED;
							end
						end
						OP_SIGNAL: begin
							if (occ_q == '0) begin
								load  = 1'b1;
								ev_d  = EV_RAISED;
								tid_d = '0;
								if (count_q != COUNT_MAX) begin
									count_d = count_q + 1'b1;
								end
							end else begin
								ram_re = 1'b1;
								head_d = head_q + 1'b1;
								occ_d  = occ_q - 1'b1;
								st_d   = ST_POP;
							end
						end
						OP_CLOSE: begin
							count_d = init_q;
							if (occ_q == '0) begin
								load  = 1'b1;
								ev_d  = EV_CLOSED_EMPTY;
								tid_d = '0;
							end else begin
								ram_re = 1'b1;
								head_d = head_q + 1'b1;
								occ_d  = occ_q - 1'b1;
								st_d   = ST_DRAIN;
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_POP: begin
				load  = 1'b1;
				ev_d  = EV_READY;
				tid_d = ram_rdata;
				st_d  = ST_IDLE;
			end
			ST_DRAIN: begin
				if (out_free) begin
					load   = 1'b1;
					ev_d   = EV_DEAD;
					tid_d  = ram_rdata;
					last_d = (occ_q == '0);
					if (occ_q != '0) begin
						ram_re = 1'b1;
						head_d = head_q + 1'b1;
						occ_d  = occ_q - 1'b1;
					end else begin
						head_d = '0;
						tail_d = '0;
						st_d   = ST_IDLE;
					end
				end
			end
			default: begin
				st_d = ST_IDLE;
			end
		endcase
		if (load) begin
			ov_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= ST_IDLE;
			init_q  <= '0;
			count_q <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			st_q    <= st_d;
			count_q <= count_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			ov_q    <= ov_d;
			if (cfg_we) begin
				init_q <= cfg_wdata;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ev_q      <= ev_d;
			tid_q     <= tid_d;
			cnt_out_q <= count_d;
			last_q    <= last_d;
		end
	end

	assign rsp.valid     = ov_q;
	assign rsp.event_res = ev_q;
	assign rsp.thread_id = tid_q;
	assign rsp.count_now = cnt_out_q;
	assign rsp.last      = last_q;

	`CSFW_ASSERT_IMP(a_occ_bound, clk, arst_n, 1'b1, occ_q <= OCC_W'(QUEUE_DEPTH))
	`CSFW_ASSERT_IMP(a_ptr_occ, clk, arst_n, 1'b1, (tail_q - head_q) == occ_q[PTR_W-1:0])
	`CSFW_ASSERT_NXT(a_pop_ready, clk, arst_n, st_q == ST_POP, rsp.valid && (rsp.event_res == EV_READY))
endmodule

@@ sim/tb_counting_semaphore_fifo_waiters.sv @@
// Self-checking bench for the counting semaphore: directed cases, then random words
`timescale 1ns / 1ps
module tb_counting_semaphore_fifo_waiters;
	import csfw_pkg::*;

	localparam int IDLE_PCT       = 29;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = QUEUE_DEPTH + 4;
	localparam int HOLD_OFF       = 80;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [EV_W-1:0]    event_res;
		logic [ID_W-1:0]    thread_id;
		logic [COUNT_W-1:0] count_now;
		logic               last;
	} sem_result_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [COUNT_W-1:0] cfg_wdata;

	csfw_req_if req_ch ();
	csfw_rsp_if rsp_ch ();

	counting_semaphore_fifo_waiters u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	logic [COUNT_W-1:0] sem_count;
	logic [COUNT_W-1:0] sem_init;
	logic [ID_W-1:0]    waiters[$];
	sem_result_t        pending_results[$];
	int                 fault_count  = 0;
	int                 quiet_cycles = 0;
	int                 rsp_hold     = 0;
	bit                 steady       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void queue_result(input logic [EV_W-1:0] ev, input logic [ID_W-1:0] tid,
			input logic lst);
		sem_result_t r;
		r = '{ev, tid, sem_count, lst};
		pending_results.push_back(r);
	endfunction

	function automatic void semaphore_step(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
		logic [ID_W-1:0] tid;
		case (op)
			OP_WAIT: begin
				if (sem_count != '0) begin
					sem_count = sem_count - 1'b1;
					queue_result(EV_GRANTED, id, 1'b1);
				end else if (waiters.size() >= QUEUE_DEPTH) begin
					queue_result(EV_FULL, id, 1'b1);
				end else begin
					waiters.push_back(id);
					queue_result(EV_BLOCKED, id, 1'b1);
				end
			end
			OP_SIGNAL: begin
				if (waiters.size() == 0) begin
					if (sem_count != COUNT_MAX)
						sem_count = sem_count + 1'b1;
					queue_result(EV_RAISED, '0, 1'b1);
				end else begin
					tid = waiters.pop_front();
					queue_result(EV_READY, tid, 1'b1);
				end
			end
			OP_CLOSE: begin
				sem_count = sem_init;
				if (waiters.size() == 0)
					queue_result(EV_CLOSED_EMPTY, '0, 1'b1);
				while (waiters.size() != 0) begin
					tid = waiters.pop_front();
					queue_result(EV_DEAD, tid, waiters.size() == 0);
				end
			end
			default: ;
		endcase
	endfunction

	// receiver side: random stalls, forced hold-off, or always ready
	initial begin
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (rsp_hold > 0) begin
				rsp_ch.ready = 1'b0;
				rsp_hold--;
			end else if (steady) begin
				rsp_ch.ready = 1'b1;
			end else begin
				rsp_ch.ready = ($urandom_range(99) >= IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : check_results
		sem_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("unexpected word: event_res %0d thread_id %0d count_now %0d last %0d",
					rsp_ch.event_res, rsp_ch.thread_id, rsp_ch.count_now, rsp_ch.last);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (rsp_ch.event_res !== want.event_res) begin
					$error("event_res: expected %0d, actual %0d", want.event_res, rsp_ch.event_res);
					fault_count++;
				end
				if (rsp_ch.thread_id !== want.thread_id) begin
					$error("thread_id: expected %0d, actual %0d", want.thread_id, rsp_ch.thread_id);
					fault_count++;
				end
				if (rsp_ch.count_now !== want.count_now) begin
					$error("count_now: expected %0d, actual %0d", want.count_now, rsp_ch.count_now);
					fault_count++;
				end
				if (rsp_ch.last !== want.last) begin
					$error("last: expected %0d, actual %0d", want.last, rsp_ch.last);
					fault_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// enter and leave at a falling edge; valid stays high for the next word
	task automatic send_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
		while (!steady && $urandom_range(99) < IDLE_PCT) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid        = 1'b1;
		req_ch.opcode       = op;
		req_ch.requester_id = id;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		semaphore_step(op, id);
		@(negedge clk);
	endtask

	task automatic settle();
		req_ch.valid = 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_initial_count(input logic [COUNT_W-1:0] value);
		cfg_we    = 1'b1;
		cfg_wdata = value;
		@(negedge clk);
		cfg_we   = 1'b0;
		sem_init = value;
	endtask

	task automatic run_random(input int n, input int wait_pct);
		int              sent;
		int              pick;
		logic [OP_W-1:0] op;
		sent = 0;
		while (sent < n) begin
			pick = $urandom_range(99);
			if (pick < 3)
				op = OP_UNUSED;
			else if (pick < 3 + wait_pct)
				op = OP_WAIT;
			else if (pick < 92)
				op = OP_SIGNAL;
			else
				op = OP_CLOSE;
			send_word(op, ID_W'($urandom_range(255)));
			if (op != OP_UNUSED)
				sent++;
		end
	endtask

	task automatic test_count_extremes();
		write_initial_count(COUNT_MAX);
		send_word(OP_CLOSE, 8'h00);
		send_word(OP_SIGNAL, 8'h00);
		send_word(OP_WAIT, 8'hFF);
		send_word(OP_SIGNAL, 8'h00);
		settle();
	endtask

	task automatic test_waiter_queue();
		write_initial_count('0);
		send_word(OP_CLOSE, 8'h00);
		send_word(OP_WAIT, 8'h00);
		send_word(OP_SIGNAL, 8'h00);
		send_word(OP_UNUSED, 8'hFF);
		for (int i = 0; i < QUEUE_DEPTH; i++)
			send_word(OP_WAIT, ID_W'(i * 17));
		send_word(OP_WAIT, 8'hA5);
		send_word(OP_CLOSE, 8'h00);
		settle();
	endtask

	task automatic test_random_mix();
		write_initial_count(16'd2);
		run_random(90, 50);
		settle();
	endtask

	task automatic test_backpressure();
		write_initial_count('0);
		rsp_hold = HOLD_OFF;
		run_random(80, 60);
		settle();
	endtask

	task automatic test_steady_saturated();
		write_initial_count(COUNT_MAX);
		steady = 1'b1;
		run_random(40, 50);
		steady = 1'b0;
		settle();
	endtask

	task automatic test_sender_pause();
		write_initial_count(COUNT_W'($urandom_range(8, 1)));
		run_random(45, 55);
		settle();
		run_random(45, 55);
		settle();
	endtask

	task automatic test_wide_init();
		write_initial_count(COUNT_W'($urandom_range(65535)));
		run_random(30, 50);
		settle();
	endtask

	initial begin
		arst_n              = 1'b0;
		cfg_we              = 1'b0;
		cfg_wdata           = '0;
		req_ch.valid        = 1'b0;
		req_ch.opcode       = OP_WAIT;
		req_ch.requester_id = '0;
		sem_count           = '0;
		sem_init            = '0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_count_extremes();
		test_waiter_queue();
		test_random_mix();
		test_backpressure();
		test_steady_saturated();
		test_sender_pause();
		test_wide_init();

		if (fault_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule

@@ counting_semaphore_fifo_waiters.f @@
+incdir+hw/rtl
hw/rtl/csfw_pkg.sv
hw/rtl/csfw_ifs.sv
hw/rtl/csfw_ram.sv
hw/rtl/counting_semaphore_fifo_waiters.sv
sim/tb_counting_semaphore_fifo_waiters.sv
